// ----- src/adns_pkg.sv -----
// Package for the ASCII decimal number scanner.
// Holds character codes, default parameter values and the power-of-ten tables.
// It depends on nothing else; every other file of the block imports it.
package adns_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned OUT_W  = 48;

  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  localparam int unsigned DEF_INT_BITS        = 32;
  localparam int unsigned DEF_FRAC_BITS       = 16;
  localparam int unsigned DEF_MAX_FRAC_DIGITS = 5;

  // Powers of ten for zero to five kept fraction digits.
  localparam int unsigned POW10 [0:5] = '{1, 10, 100, 1000, 10000, 100000};

  // Smallest s with 2^s >= 10^n; sets the precision of each reciprocal.
  localparam int unsigned FRAC_SHIFT [0:5] = '{0, 4, 7, 10, 14, 17};

  // Sign and saturation of a finished number.
  typedef struct packed {
    logic negative;
    logic saturated;
  } adns_flags_t;

endpackage

// ----- src/adns_if.sv -----
// Handshake channels of the ASCII decimal number scanner.
// One channel carries characters, the other carries parsed results.
// Depends on adns_pkg for the field widths.
interface adns_char_if import adns_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;

  modport source (output valid, output character, input ready);
  modport sink (input valid, input character, output ready);
endinterface

interface adns_result_if import adns_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] value;
  logic                    overflow;

  modport source (output valid, output value, output overflow, input ready);
  modport sink (input valid, input value, input overflow, output ready);
endinterface

// ----- src/adns_scale.sv -----
// Result pipeline of the ASCII decimal number scanner: scales the kept fraction
// digits to binary by a reciprocal multiply, then joins, clamps and signs the value.
// Depends on adns_pkg.
module adns_scale import adns_pkg::*; #(
  parameter int unsigned INT_BITS        = DEF_INT_BITS,
  parameter int unsigned FRAC_BITS       = DEF_FRAC_BITS,
  parameter int unsigned MAX_FRAC_DIGITS = DEF_MAX_FRAC_DIGITS,
  localparam int unsigned FACC_W = $clog2(POW10[MAX_FRAC_DIGITS]),
  localparam int unsigned CNT_W  = $clog2(MAX_FRAC_DIGITS + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    adv_i,
  input  logic                    in_valid_i,
  input  adns_flags_t             in_flags_i,
  input  logic [INT_BITS-1:0]     in_int_i,
  input  logic [FACC_W-1:0]       in_frac_i,
  input  logic [CNT_W-1:0]        in_cnt_i,
  output logic                    out_valid_o,
  output logic signed [OUT_W-1:0] out_value_o,
  output logic                    out_overflow_o
);

  localparam int unsigned DEPTH   = MAX_FRAC_DIGITS + 1;
  localparam int unsigned PW      = $clog2(POW10[MAX_FRAC_DIGITS] + 1);
  localparam int unsigned RW      = FRAC_BITS + 1;
  localparam int unsigned PRODW   = FACC_W + RW;
  localparam int unsigned XW      = FACC_W + FRAC_BITS;
  localparam int unsigned QW      = FRAC_BITS + 1;
  localparam int unsigned SHW     = 5;
  localparam int unsigned MAGW    = INT_BITS + FRAC_BITS + 1;
  localparam int unsigned LIM_EXP = (INT_BITS - 1 + FRAC_BITS < OUT_W - 1) ?
                                    (INT_BITS - 1 + FRAC_BITS) : (OUT_W - 1);

  logic [RW-1:0]  recip_tab [DEPTH];
  logic [PW-1:0]  pow_tab   [DEPTH];
  logic [PW-1:0]  half_tab  [DEPTH];
  logic [SHW-1:0] shift_tab [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_tab
    localparam logic [RW-1:0] RECIP =
      RW'(((64'd1) << (FRAC_SHIFT[k] + FRAC_BITS)) / POW10[k]);
    assign recip_tab[k] = RECIP;
    assign pow_tab[k]   = PW'(POW10[k]);
    assign half_tab[k]  = PW'(POW10[k] / 2);
    assign shift_tab[k] = SHW'(FRAC_SHIFT[k]);
  end

  // Stage a: captured number.
  logic                vld_a_q;
  adns_flags_t         flg_a_q;
  logic [INT_BITS-1:0] int_a_q;
  logic [FACC_W-1:0]   frac_a_q;
  logic [CNT_W-1:0]    cnt_a_q;
  // Stage b: reciprocal product.
  logic                vld_b_q;
  adns_flags_t         flg_b_q;
  logic [INT_BITS-1:0] int_b_q;
  logic [CNT_W-1:0]    cnt_b_q;
  logic [PRODW-1:0]    prod_b_q;
  logic [XW-1:0]       x_b_q;
  // Stage c: quotient estimate and its back product.
  logic                vld_c_q;
  adns_flags_t         flg_c_q;
  logic [INT_BITS-1:0] int_c_q;
  logic [CNT_W-1:0]    cnt_c_q;
  logic [XW-1:0]       x_c_q;
  logic [QW-1:0]       q0_c_q;
  logic [XW-1:0]       qp_c_q;
  // Stage d: rounded fraction.
  logic                vld_d_q;
  adns_flags_t         flg_d_q;
  logic [INT_BITS-1:0] int_d_q;
  logic [QW-1:0]       q_d_q;
  // Stage e: clamped magnitude.
  logic                vld_e_q;
  logic                neg_e_q;
  logic [LIM_EXP:0]    mag_e_q;
  logic                ovf_e_q;
  // Result register.
  logic                    out_vld_q;
  logic signed [OUT_W-1:0] value_q;
  logic                    ovf_q;

  logic [PRODW-1:0] prod_a;
  logic [XW-1:0]    x_a;
  logic [QW-1:0]    q0_b;
  logic [XW-1:0]    qp_b;
  logic [XW-1:0]    r_c;
  logic [XW-1:0]    p_c;
  logic             inc1_c;
  logic             inc2_c;
  logic [QW-1:0]    q_c;
  logic [MAGW-1:0]  mag_d;
  logic [MAGW-1:0]  lim_d;
  logic             over_d;
  logic [LIM_EXP:0] mag_e_d;
  logic [OUT_W-1:0] m_e;
  logic [OUT_W-1:0] value_d;

  // The fraction D of n digits becomes round(D * 2^FRAC_BITS / 10^n). The
  // reciprocal estimate is at most two below the true quotient, so the
  // remainder against 10^n picks one of three corrections.
  always_comb begin
    prod_a = PRODW'(frac_a_q) * PRODW'(recip_tab[cnt_a_q]);
    x_a    = (XW'(frac_a_q) << FRAC_BITS) + XW'(half_tab[cnt_a_q]);

    q0_b = QW'(prod_b_q >> shift_tab[cnt_b_q]);
    qp_b = XW'(q0_b) * XW'(pow_tab[cnt_b_q]);

    r_c    = x_c_q - qp_c_q;
    p_c    = XW'(pow_tab[cnt_c_q]);
    inc1_c = r_c >= p_c;
    inc2_c = r_c >= (p_c << 1);
    q_c    = q0_c_q + QW'(inc1_c) + QW'(inc2_c);

    mag_d   = (MAGW'(int_d_q) << FRAC_BITS) + MAGW'(q_d_q);
    lim_d   = (MAGW'(1) << LIM_EXP) - MAGW'(!flg_d_q.negative);
    over_d  = flg_d_q.saturated || (mag_d > lim_d);
    mag_e_d = over_d ? lim_d[LIM_EXP:0] : mag_d[LIM_EXP:0];

    m_e     = OUT_W'(mag_e_q);
    value_d = neg_e_q ? (OUT_W'(0) - m_e) : m_e;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q   <= 1'b0;
      vld_b_q   <= 1'b0;
      vld_c_q   <= 1'b0;
      vld_d_q   <= 1'b0;
      vld_e_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_a_q   <= in_valid_i;
      vld_b_q   <= vld_a_q;
      vld_c_q   <= vld_b_q;
      vld_d_q   <= vld_c_q;
      vld_e_q   <= vld_d_q;
      out_vld_q <= vld_e_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      flg_a_q  <= in_flags_i;
      int_a_q  <= in_int_i;
      frac_a_q <= in_frac_i;
      cnt_a_q  <= in_cnt_i;

      flg_b_q  <= flg_a_q;
      int_b_q  <= int_a_q;
      cnt_b_q  <= cnt_a_q;
      prod_b_q <= prod_a;
      x_b_q    <= x_a;

      flg_c_q  <= flg_b_q;
      int_c_q  <= int_b_q;
      cnt_c_q  <= cnt_b_q;
      x_c_q    <= x_b_q;
      q0_c_q   <= q0_b;
      qp_c_q   <= qp_b;

      flg_d_q  <= flg_c_q;
      int_d_q  <= int_c_q;
      q_d_q    <= q_c;

      neg_e_q  <= flg_d_q.negative;
      mag_e_q  <= mag_e_d;
      ovf_e_q  <= over_d;

      value_q  <= $signed(value_d);
      ovf_q    <= ovf_e_q;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign out_value_o    = value_q;
  assign out_overflow_o = ovf_q;

`ifndef ASSERT_OFF
  // The quotient estimate never falls more than two short.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_c_q |-> r_c < ((p_c << 1) + p_c))
    else $error("fraction remainder out of range");

  // A rounded fraction never exceeds one whole unit.
  a_frac_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_d_q |-> q_d_q <= (QW'(1) << FRAC_BITS))
    else $error("scaled fraction too large");

  // The pipeline holds all its stages while the result waits.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> $stable({vld_a_q, vld_b_q, vld_c_q, vld_d_q, vld_e_q, out_vld_q}))
    else $error("pipeline moved while stalled");
`endif

endmodule

// ----- src/ascii_decimal_number_scanner_unit.sv -----
// Top level of the ASCII decimal number scanner.
// Scans characters into integer and fraction accumulators and feeds adns_scale.
// Depends on adns_pkg, adns_if (channels) and adns_scale.
//
// The block takes one ASCII character per item and returns a signed fixed-point
// number with FRAC_BITS fraction bits each time a number ends. Characters are
// skipped until a minus sign or a digit starts a number; digits then build the
// integer part, and when fraction_mode is set a dot starts up to MAX_FRAC_DIGITS
// kept fraction digits (later ones are dropped). The first character that cannot
// continue the number is consumed and ends it, producing one result; a lone minus
// gives zero. An integer part that grows past INT_BITS signed bits clamps to the
// most positive or most negative code and raises overflow, as does a rounding
// carry past the output range. One character is taken every clock cycle unless
// the input stalls: the scan state is updated by a single multiply-by-ten-and-add
// step per cycle. A result is ready once the fraction has been scaled by a
// reciprocal multiply, a back multiply with correction, and the final clamp and
// sign stages. The input stalls only while a result sits in the output register
// and is not taken. fraction_mode should be written only while the block is idle.
module ascii_decimal_number_scanner_unit import adns_pkg::*; #(
  parameter int unsigned INT_BITS        = DEF_INT_BITS,
  parameter int unsigned FRAC_BITS       = DEF_FRAC_BITS,
  parameter int unsigned MAX_FRAC_DIGITS = DEF_MAX_FRAC_DIGITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  adns_char_if.sink     char_i,
  adns_result_if.source res_o
);

  localparam int unsigned FACC_W = $clog2(POW10[MAX_FRAC_DIGITS]);
  localparam int unsigned CNT_W  = $clog2(MAX_FRAC_DIGITS + 1);
  localparam int unsigned ACC_W  = INT_BITS + 4;
  localparam int unsigned FNX_W  = FACC_W + 4;

  localparam logic [INT_BITS-1:0] INT_TOP = {1'b1, {(INT_BITS - 1){1'b0}}};

  // Scan phases.
  localparam logic [1:0] PH_SKIP = 2'd0;
  localparam logic [1:0] PH_INT  = 2'd1;
  localparam logic [1:0] PH_FRAC = 2'd2;

  logic                mode_q;
  logic [1:0]          phase_q, phase_d;
  logic                neg_q, neg_d;
  logic                sat_q, sat_d;
  logic [INT_BITS-1:0] iacc_q, iacc_d;
  logic [FACC_W-1:0]   facc_q, facc_d;
  logic [CNT_W-1:0]    fcnt_q, fcnt_d;

  logic                adv;
  logic                ch_acc;
  logic                is_dig;
  logic [3:0]          digit;
  logic [INT_BITS-1:0] int_lim;
  logic [ACC_W-1:0]    int_next;
  logic [FNX_W-1:0]    frac_next;
  logic                emit;
  adns_flags_t         flags;
  logic                s_valid;

  // Everything moves unless a finished result is waiting for its taker.
  assign adv          = !(s_valid && !res_o.ready);
  assign char_i.ready = adv;
  assign ch_acc       = char_i.valid && adv;

  assign is_dig    = (char_i.character >= CH_ZERO) && (char_i.character <= CH_NINE);
  assign digit     = char_i.character[3:0];
  assign int_lim   = INT_TOP - INT_BITS'(!neg_q);
  assign int_next  = ACC_W'({iacc_q, 3'b000}) + ACC_W'({iacc_q, 1'b0}) + ACC_W'(digit);
  assign frac_next = FNX_W'({facc_q, 3'b000}) + FNX_W'({facc_q, 1'b0}) + FNX_W'(digit);

  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    sat_d   = sat_q;
    iacc_d  = iacc_q;
    facc_d  = facc_q;
    fcnt_d  = fcnt_q;
    emit    = 1'b0;
    if (ch_acc) begin
      unique case (phase_q)
        PH_INT: begin
          if (is_dig) begin
            if (sat_q || (int_next > ACC_W'(int_lim))) begin
              iacc_d = int_lim;
              sat_d  = 1'b1;
            end else begin
              iacc_d = int_next[INT_BITS-1:0];
            end
          end else if ((char_i.character == CH_DOT) && mode_q) begin
            phase_d = PH_FRAC;
          end else begin
            emit = 1'b1;
          end
        end
        PH_FRAC: begin
          if (is_dig) begin
            if (fcnt_q < CNT_W'(MAX_FRAC_DIGITS)) begin
              facc_d = frac_next[FACC_W-1:0];
              fcnt_d = fcnt_q + CNT_W'(1);
            end
          end else begin
            emit = 1'b1;
          end
        end
        default: begin
          // Skipping; the unused phase code behaves the same way.
          if (char_i.character == CH_MINUS) begin
            phase_d = PH_INT;
            neg_d   = 1'b1;
            sat_d   = 1'b0;
            iacc_d  = '0;
            facc_d  = '0;
            fcnt_d  = '0;
          end else if (is_dig) begin
            phase_d = PH_INT;
            neg_d   = 1'b0;
            sat_d   = 1'b0;
            iacc_d  = INT_BITS'(digit);
            facc_d  = '0;
            fcnt_d  = '0;
          end else begin
            phase_d = PH_SKIP;
          end
        end
      endcase
      // A finished number hands its state to the pipeline and starts over.
      if (emit) begin
        phase_d = PH_SKIP;
        neg_d   = 1'b0;
        sat_d   = 1'b0;
        iacc_d  = '0;
        facc_d  = '0;
        fcnt_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      phase_q <= PH_SKIP;
      neg_q   <= 1'b0;
      sat_q   <= 1'b0;
      iacc_q  <= '0;
      facc_q  <= '0;
      fcnt_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      phase_q <= phase_d;
      neg_q   <= neg_d;
      sat_q   <= sat_d;
      iacc_q  <= iacc_d;
      facc_q  <= facc_d;
      fcnt_q  <= fcnt_d;
    end
  end

  assign flags.negative  = neg_q;
  assign flags.saturated = sat_q;

  adns_scale #(
    .INT_BITS        (INT_BITS),
    .FRAC_BITS       (FRAC_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_scale (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv),
    .in_valid_i     (emit),
    .in_flags_i     (flags),
    .in_int_i       (iacc_q),
    .in_frac_i      (facc_q),
    .in_cnt_i       (fcnt_q),
    .out_valid_o    (s_valid),
    .out_value_o    (res_o.value),
    .out_overflow_o (res_o.overflow)
  );

  assign res_o.valid = s_valid;

`ifndef ASSERT_OFF
  // Once saturated, the integer part stays pinned at its limit.
  a_sat_pinned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sat_q |-> iacc_q == int_lim)
    else $error("saturated integer part left its limit");

  // The kept digit count never passes its maximum.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q <= CNT_W'(MAX_FRAC_DIGITS))
    else $error("fraction digit count too large");

  // While skipping, no number is half built.
  a_skip_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_SKIP |-> iacc_q == '0 && !neg_q && !sat_q && facc_q == '0 && fcnt_q == '0)
    else $error("stale number state while skipping");

  // Fraction digits exist only in the fraction phase.
  a_frac_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_FRAC |-> fcnt_q == '0 && facc_q == '0)
    else $error("fraction state outside fraction phase");
`endif

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the ASCII decimal number scanner.
// Needs adns_pkg, the adns_if channels and ascii_decimal_number_scanner_unit.
// A directed table runs first, then random numbers are checked against a predictor.
module testbench;
  import adns_pkg::*;

  // The predictor uses the same sizes as the default build of the block.
  localparam int unsigned INT_BITS        = DEF_INT_BITS;
  localparam int unsigned FRAC_BITS       = DEF_FRAC_BITS;
  localparam int unsigned MAX_FRAC_DIGITS = DEF_MAX_FRAC_DIGITS;

  // Values of the fraction_mode register.
  localparam logic MODE_INT  = 1'b0;
  localparam logic MODE_FRAC = 1'b1;

  // Margin waited after the last pending number arrives, for items without a result.
  localparam int unsigned LATENCY_WAIT = 10;
  // Cycles without a transfer on either channel before the run is declared hung.
  localparam int unsigned STALL_LIMIT = 4000;
  // Counted items per random phase.
  localparam int unsigned PHASE_ITEMS = 300;

  typedef enum logic [1:0] {
    PH_SKIP = 2'd0,
    PH_INT  = 2'd1,
    PH_FRAC = 2'd2
  } scan_phase_e;

  typedef struct packed {
    logic signed [OUT_W-1:0] value;
    logic                    overflow;
  } parsed_number_t;

  // One row of the directed table. The expected number is typed in only where it
  // is obvious; the other rows are left to the predictor.
  typedef struct packed {
    logic [CHAR_W-1:0]       ch;
    logic                    mode;
    logic                    typed;
    logic signed [OUT_W-1:0] value;
    logic                    overflow;
  } dir_row_t;

  localparam int NUM_DIRECTED = 27;

  dir_row_t directed_rows [NUM_DIRECTED] = '{
    // Integer mode: a NUL byte is skipped, a dot ends the number.
    '{8'h00,    MODE_INT,  1'b0, 48'sd0,       1'b0},
    '{CH_NINE,  MODE_INT,  1'b0, 48'sd0,       1'b0},
    '{CH_DOT,   MODE_INT,  1'b1, 48'sd589824,  1'b0},
    // A lone minus ended by the all-ones byte gives zero.
    '{CH_MINUS, MODE_INT,  1'b0, 48'sd0,       1'b0},
    '{8'hFF,    MODE_INT,  1'b1, 48'sd0,       1'b0},
    // Ten nines saturate the integer part at the most positive code.
    '{CH_NINE,  MODE_INT,  1'b0, 48'sd0,       1'b0},
    '{CH_NINE,  MODE_INT,  1'b0, 48'sd0,       1'b0},
    '{CH_NINE,  MODE_INT,  1'b0, 48'sd0,       1'b0},
    '{CH_NINE,  MODE_INT,  1'b0, 48'sd0,       1'b0},
    '{CH_NINE,  MODE_INT,  1'b0, 48'sd0,       1'b0},
    '{CH_NINE,  MODE_INT,  1'b0, 48'sd0,       1'b0},
    '{CH_NINE,  MODE_INT,  1'b0, 48'sd0,       1'b0},
    '{CH_NINE,  MODE_INT,  1'b0, 48'sd0,       1'b0},
    '{CH_NINE,  MODE_INT,  1'b0, 48'sd0,       1'b0},
    '{CH_NINE,  MODE_INT,  1'b0, 48'sd0,       1'b0},
    '{8'h41,    MODE_INT,  1'b1, 48'sh7FFF_FFFF_FFFF, 1'b1},
    // The number starts in integer mode and the mode changes before its dot.
    '{CH_ZERO,  MODE_INT,  1'b0, 48'sd0,       1'b0},
    '{CH_DOT,   MODE_FRAC, 1'b0, 48'sd0,       1'b0},
    '{8'h31,    MODE_FRAC, 1'b0, 48'sd0,       1'b0},
    '{8'h20,    MODE_FRAC, 1'b0, 48'sd0,       1'b0},
    // Minus followed directly by a dot gives minus one half.
    '{CH_MINUS, MODE_FRAC, 1'b0, 48'sd0,       1'b0},
    '{CH_DOT,   MODE_FRAC, 1'b0, 48'sd0,       1'b0},
    '{8'h35,    MODE_FRAC, 1'b0, 48'sd0,       1'b0},
    '{8'h2F,    MODE_FRAC, 1'b1, -48'sd32768,  1'b0},
    // A trailing dot leaves the fraction at zero.
    '{8'h37,    MODE_FRAC, 1'b0, 48'sd0,       1'b0},
    '{CH_DOT,   MODE_FRAC, 1'b0, 48'sd0,       1'b0},
    '{8'h3A,    MODE_FRAC, 1'b1, 48'sd458752,  1'b0}
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  adns_char_if   char_ch ();
  adns_result_if res_ch ();

  ascii_decimal_number_scanner_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .char_i      (char_ch),
    .res_o       (res_ch)
  );

  // Predictor state: a private copy of the scanner and its register.
  scan_phase_e sc_phase;
  logic        sc_neg;
  logic [63:0] sc_int;
  logic [63:0] sc_frac;
  int unsigned sc_nfrac;
  logic        sc_sat;
  logic        sc_frac_mode;

  parsed_number_t pending_numbers [$];

  int unsigned mismatch_count = 0;
  int unsigned counted_items  = 0;
  int unsigned src_idle_pct   = 0;
  int unsigned snk_stall_pct  = 0;
  int unsigned quiet_cycles   = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  task automatic clear_scan();
    sc_phase = PH_SKIP;
    sc_neg   = 1'b0;
    sc_int   = '0;
    sc_frac  = '0;
    sc_nfrac = 0;
    sc_sat   = 1'b0;
  endtask

  // Builds the fixed-point number from the accumulated digits, clamps it to the
  // signed range and applies the sign. The scan state is then cleared.
  task automatic finish_number(output parsed_number_t num);
    logic [63:0] lim;
    logic [63:0] lim_out;
    logic [63:0] mag;
    logic [63:0] p;
    logic [63:0] f;
    logic        ovf;
    int unsigned n;
    lim     = (64'd1 << (INT_BITS - 1 + FRAC_BITS)) - {63'd0, ~sc_neg};
    lim_out = (64'd1 << (OUT_W - 1)) - {63'd0, ~sc_neg};
    if (lim_out < lim) lim = lim_out;
    n   = (sc_nfrac > MAX_FRAC_DIGITS) ? MAX_FRAC_DIGITS : sc_nfrac;
    ovf = sc_sat;
    if (sc_sat) begin
      mag = lim;
    end else begin
      p = 64'd1;
      repeat (n) p = p * 64'd10;
      // Round half up while scaling the decimal fraction to binary.
      f   = ((sc_frac << FRAC_BITS) + p / 64'd2) / p;
      mag = (sc_int << FRAC_BITS) + f;
      if (mag > lim) begin
        mag = lim;
        ovf = 1'b1;
      end
    end
    if (sc_neg) mag = -mag;
    num.value    = mag[OUT_W-1:0];
    num.overflow = ovf;
    clear_scan();
  endtask

  // Advances the predictor by one item; done is set when the item ends a number.
  task automatic scan_char(input logic [CHAR_W-1:0] c, output bit done,
                           output parsed_number_t num);
    logic [63:0] lim;
    logic [63:0] nxt;
    logic [63:0] digit;
    done  = 1'b0;
    num   = '0;
    digit = {56'd0, c - CH_ZERO};
    case (sc_phase)
      PH_INT: begin
        if (is_digit(c)) begin
          lim = (64'd1 << (INT_BITS - 1)) - {63'd0, ~sc_neg};
          nxt = sc_int * 64'd10 + digit;
          // Once clamped, the integer part stays at its limit.
          if (sc_sat || nxt > lim) begin
            sc_int = lim;
            sc_sat = 1'b1;
          end else begin
            sc_int = nxt;
          end
        end else if (c == CH_DOT && sc_frac_mode == MODE_FRAC) begin
          sc_phase = PH_FRAC;
        end else begin
          finish_number(num);
          done = 1'b1;
        end
      end
      PH_FRAC: begin
        if (is_digit(c)) begin
          // Digits past the kept count are dropped.
          if (sc_nfrac < MAX_FRAC_DIGITS) begin
            sc_frac  = sc_frac * 64'd10 + digit;
            sc_nfrac = sc_nfrac + 1;
          end
        end else begin
          finish_number(num);
          done = 1'b1;
        end
      end
      default: begin
        // Skipping; the unused phase code behaves the same way.
        if (c == CH_MINUS) begin
          clear_scan();
          sc_neg   = 1'b1;
          sc_phase = PH_INT;
        end else if (is_digit(c)) begin
          clear_scan();
          sc_int   = digit;
          sc_phase = PH_INT;
        end else begin
          sc_phase = PH_SKIP;
        end
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic signed [OUT_W-1:0] got,
                                 input logic signed [OUT_W-1:0] want);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count = mismatch_count + 1;
  endtask

  // Offers one item, with random idle cycles before it, and waits for it to be
  // taken. The predictor runs on the accepting edge. A typed expectation, when
  // given, replaces the predicted number.
  task automatic send_char(input logic [CHAR_W-1:0] c, input bit has_typed,
                           input parsed_number_t typed);
    bit             done;
    bit             counts;
    parsed_number_t num;
    while ($urandom_range(99) < src_idle_pct) begin
      char_ch.valid <= 1'b0;
      @(posedge clk);
    end
    char_ch.valid     <= 1'b1;
    char_ch.character <= c;
    @(posedge clk);
    while (!char_ch.ready) @(posedge clk);
    // Items skipped between numbers do not count toward the phase length.
    counts = (sc_phase == PH_INT) || (sc_phase == PH_FRAC) || is_digit(c) || (c == CH_MINUS);
    if (counts) counted_items = counted_items + 1;
    scan_char(c, done, num);
    if (done) pending_numbers.push_back(has_typed ? typed : num);
  endtask

  // Stops offering items until every pending number has arrived, then waits a
  // little longer so that items without a result have settled as well.
  task automatic idle_until_drained(input int unsigned extra);
    char_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_numbers.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_fraction_mode(input logic mode);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we       <= 1'b0;
    sc_frac_mode  = mode;
  endtask

  // One random token: mostly a well-formed number with random content, the rest
  // arbitrary bytes. Numbers cover leading zeros, the saturation boundary, long
  // digit strings, missing integer digits, and fractions past the kept count.
  task automatic send_random_token();
    string             digits;
    int unsigned       pick;
    int unsigned       nfrac;
    bit                nines;
    logic [CHAR_W-1:0] term;
    pick = $urandom_range(99);
    if (pick < 15) begin
      repeat ($urandom_range(4, 1)) send_char(CHAR_W'($urandom_range(255)), 1'b0, '0);
    end else begin
      if ($urandom_range(9) < 3) send_char(CH_MINUS, 1'b0, '0);
      pick = $urandom_range(99);
      if (pick < 8) digits = "";
      else if (pick < 70) digits = $sformatf("%0d", $urandom_range(99999));
      else if (pick < 80) digits = $sformatf("0%0d", $urandom_range(999));
      else if (pick < 90) digits = $sformatf("%0d", 32'd2147483646 + $urandom_range(3));
      else digits = $sformatf("%0d%0d", $urandom, $urandom_range(99));
      for (int i = 0; i < digits.len(); i++) send_char(digits[i], 1'b0, '0);
      if ($urandom_range(9) < 6) begin
        send_char(CH_DOT, 1'b0, '0);
        nfrac = $urandom_range(8);
        nines = ($urandom_range(9) == 0);
        repeat (nfrac) begin
          send_char(nines ? CH_NINE : CHAR_W'(CH_ZERO + $urandom_range(9)),
                    1'b0, '0);
        end
      end
      pick = $urandom_range(99);
      if (pick < 15) begin
        term = CH_DOT;
      end else if (pick < 25) begin
        term = CH_MINUS;
      end else begin
        term = CHAR_W'($urandom_range(255));
        while (is_digit(term)) term = CHAR_W'($urandom_range(255));
      end
      send_char(term, 1'b0, '0);
    end
  endtask

  // One random phase with its own idle rates and register setting. A space at
  // the end closes any open number so the register is written with the block idle.
  task automatic run_phase(input int unsigned src_pct, input int unsigned snk_pct,
                           input logic mode);
    int unsigned start;
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    set_fraction_mode(mode);
    start = counted_items;
    while (counted_items - start < PHASE_ITEMS) begin
      send_random_token();
      // Now and then the sender holds off until the output side is empty.
      if ($urandom_range(149) == 0) idle_until_drained(0);
    end
    send_char(8'h20, 1'b0, '0);
    idle_until_drained(LATENCY_WAIT);
  endtask

  // Receiver: ready is redrawn every cycle from the current stall rate.
  initial begin : result_sink
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Every accepted number is compared with the oldest pending one.
  always @(posedge clk) begin : check_numbers
    parsed_number_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_numbers.size() == 0) begin
        report_mismatch("number with none pending", res_ch.value, '0);
      end else begin
        want = pending_numbers.pop_front();
        if (res_ch.value !== want.value) report_mismatch("value", res_ch.value, want.value);
        if (res_ch.overflow !== want.overflow) begin
          report_mismatch("overflow", {47'd0, res_ch.overflow}, {47'd0, want.overflow});
        end
      end
    end
  end

  // Watchdog: ends the run when neither channel moves for too long.
  always @(posedge clk) begin
    if ((char_ch.valid && char_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t       row;
    parsed_number_t typed;
    logic           cur_mode;
    char_ch.valid     <= 1'b0;
    char_ch.character <= '0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= 1'b0;
    rst_n             <= 1'b0;
    clear_scan();
    sc_frac_mode = MODE_INT;
    cur_mode     = MODE_INT;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. The register keeps its reset value until a row asks for a
    // different mode; the change is made only once the output side is empty.
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      row = directed_rows[i];
      if (row.mode != cur_mode) begin
        idle_until_drained(LATENCY_WAIT);
        set_fraction_mode(row.mode);
        cur_mode = row.mode;
      end
      typed.value    = row.value;
      typed.overflow = row.overflow;
      send_char(row.ch, row.typed, typed);
    end
    idle_until_drained(LATENCY_WAIT);

    // Random phases: no idling, sender idle, receiver stalling, then both.
    run_phase(0, 0, MODE_FRAC);
    run_phase(76, 0, MODE_INT);
    run_phase(0, 76, MODE_FRAC);
    run_phase(15, 15, MODE_FRAC);

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
